[hw/rtl/rect_region_membership_table_assert.svh]
// Assertion macros for the rectangle region membership table.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef RECT_REGION_MEMBERSHIP_TABLE_ASSERT_SVH
`define RECT_REGION_MEMBERSHIP_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RRMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrmt check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RRMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrmt check failed");

`endif

[hw/rtl/rrmt_pkg.sv]
// Shared types and constants for the rectangle region membership table.
// No dependencies; used by every module of the block.
`default_nettype none

package rrmt_pkg;

    localparam int MAX_ADDED_DEF      = 16;
    localparam int MAX_SUBTRACTED_DEF = 16;

    localparam int COORD_W     = 32;
    localparam int ACTION_W    = 3;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 6 * COORD_W;
    localparam int OUT_FIELD_W = 1 + 4 * COORD_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR  = 3'd0,
        ACT_ADD    = 3'd1,
        ACT_SUB    = 3'd2,
        ACT_SET    = 3'd3,
        ACT_TEST   = 3'd4,
        ACT_BOUNDS = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // Inclusive rectangle; first member sits in the high bits.
    typedef struct packed {
        logic signed [COORD_W-1:0] hi_z;
        logic signed [COORD_W-1:0] hi_x;
        logic signed [COORD_W-1:0] lo_z;
        logic signed [COORD_W-1:0] lo_x;
    } t_rect;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] x;
    } t_point;

    localparam int RECT_W = $bits(t_rect);

endpackage

`default_nettype wire

[hw/rtl/rrmt_rect_store.sv]
// Rectangle store: one write port, one registered read port.
// Depends on rrmt_pkg for the rectangle type.
`default_nettype none

module rrmt_rect_store #(
    parameter int DEPTH = rrmt_pkg::MAX_ADDED_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire logic [AW-1:0]  i_waddr,
    input  wire rrmt_pkg::t_rect i_wdata,
    input  wire logic [AW-1:0]  i_raddr,
    output rrmt_pkg::t_rect     o_rdata
);
    import rrmt_pkg::*;

    t_rect r_mem [DEPTH];
    t_rect r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/rrmt_hit_unit.sv]
// Shared point-in-rectangle comparator used by both table scans.
// Depends on rrmt_pkg for the rectangle and point types.
`default_nettype none

module rrmt_hit_unit (
    input  wire rrmt_pkg::t_rect  i_rect,
    input  wire rrmt_pkg::t_point i_pt,
    output logic                  o_hit
);
    import rrmt_pkg::*;

    // An inverted rectangle fails one of these and holds nothing.
    assign o_hit = (i_pt.x >= i_rect.lo_x) && (i_pt.x <= i_rect.hi_x) &&
                   (i_pt.z >= i_rect.lo_z) && (i_pt.z <= i_rect.hi_z);

endmodule

`default_nettype wire

[hw/rtl/rect_region_membership_table.sv]
// Rectangle region membership table: top level with the scan sequencer.
// Depends on rrmt_pkg, rrmt_rect_store, rrmt_hit_unit and the assert header.
//
// Usage:
//   Slave stream s_axis carries one command per transaction: tuser holds the
//   action (clear, add, subtract, set, test point, bounds), tdata holds the
//   rectangle corners and the test point. Master stream m_axis returns exactly
//   one result per command: tdata holds inside_res and the bounding box, tuser
//   holds the status (ok, table full, empty selection).
//   Clear, add, subtract, set, bounds and unknown actions finish in the cycle
//   of acceptance; the result is valid on the next cycle.
//   A point test scans the added table and, once an added entry holds the
//   point, the subtracted table, one entry per cycle through a single
//   registered read port and one shared comparator; the scan stops early
//   on the deciding entry.
//   One command is in flight at a time. s_axis_tready is high while the
//   sequencer is idle and the output register is empty or draining, so a
//   stalled receiver holds the result and blocks the next command.
//   Synchronous active-low reset empties both tables, zeroes the bounding box
//   and drops any pending result; table contents themselves are not cleared.
`default_nettype none

`include "rect_region_membership_table_assert.svh"

module rect_region_membership_table #(
    parameter int MAX_ADDED      = rrmt_pkg::MAX_ADDED_DEF,
    parameter int MAX_SUBTRACTED = rrmt_pkg::MAX_SUBTRACTED_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // tdata: min_x, min_z, max_x, max_z, point_x, point_z (lowest bit up)
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [rrmt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: action
    input  wire logic [rrmt_pkg::ACTION_W-1:0]       s_axis_tuser,
    // tdata: inside_res, box_min_x, box_min_z, box_max_x, box_max_z, zero pad
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [rrmt_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // tuser: status
    output logic [rrmt_pkg::STATUS_W-1:0]            m_axis_tuser
);
    import rrmt_pkg::*;

    localparam int AW_A = (MAX_ADDED > 1) ? $clog2(MAX_ADDED) : 1;
    localparam int AW_S = (MAX_SUBTRACTED > 1) ? $clog2(MAX_SUBTRACTED) : 1;
    localparam int CW_A = $clog2(MAX_ADDED + 1);
    localparam int CW_S = $clog2(MAX_SUBTRACTED + 1);
    localparam int IW   = (CW_A > CW_S) ? CW_A : CW_S;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN_A,
        S_SCAN_S
    } t_state;

    t_state            r_state,      n_state;
    logic [CW_A-1:0]   r_cnt_a,      n_cnt_a;
    logic [CW_S-1:0]   r_cnt_s,      n_cnt_s;
    t_rect             r_box,        n_box;
    logic [IW-1:0]     r_idx,        n_idx;
    logic              r_pend,       n_pend;
    t_point            r_pt,         n_pt;
    logic              r_out_vld,    n_out_vld;
    logic              r_out_inside, n_out_inside;
    t_rect             r_out_box,    n_out_box;
    t_status           r_out_status, n_out_status;

    logic     in_acc;
    t_action  act;
    t_rect    in_rect;
    t_point   in_pt;
    logic     we_a, we_s;
    logic [AW_A-1:0] waddr_a;
    t_rect    rd_a, rd_s, cmp_rect;
    logic     hit, issue;
    logic     full_a, full_s;

    // Unpack the command.
    assign act        = t_action'(s_axis_tuser);
    assign in_rect.lo_x = s_axis_tdata[1*COORD_W-1:0*COORD_W];
    assign in_rect.lo_z = s_axis_tdata[2*COORD_W-1:1*COORD_W];
    assign in_rect.hi_x = s_axis_tdata[3*COORD_W-1:2*COORD_W];
    assign in_rect.hi_z = s_axis_tdata[4*COORD_W-1:3*COORD_W];
    assign in_pt.x      = s_axis_tdata[5*COORD_W-1:4*COORD_W];
    assign in_pt.z      = s_axis_tdata[6*COORD_W-1:5*COORD_W];

    // Accept only when idle and the output register is free by next edge.
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_vld || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign full_a = (r_cnt_a >= CW_A'(MAX_ADDED));
    assign full_s = (r_cnt_s >= CW_S'(MAX_SUBTRACTED));

    // Table writes: append on add/subtract, overwrite entry zero on set.
    assign we_a    = in_acc && (((act == ACT_ADD) && !full_a) || (act == ACT_SET));
    assign waddr_a = (act == ACT_SET) ? '0 : r_cnt_a[AW_A-1:0];
    assign we_s    = in_acc && (act == ACT_SUB) && !full_s;

    rrmt_rect_store #(
        .DEPTH (MAX_ADDED),
        .AW    (AW_A)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr_a),
        .i_wdata (in_rect),
        .i_raddr (r_idx[AW_A-1:0]),
        .o_rdata (rd_a)
    );

    rrmt_rect_store #(
        .DEPTH (MAX_SUBTRACTED),
        .AW    (AW_S)
    ) u_store_s (
        .i_clk   (i_clk),
        .i_we    (we_s),
        .i_waddr (r_cnt_s[AW_S-1:0]),
        .i_wdata (in_rect),
        .i_raddr (r_idx[AW_S-1:0]),
        .o_rdata (rd_s)
    );

    // One comparator serves both scans; the state picks the table.
    assign cmp_rect = (r_state == S_SCAN_A) ? rd_a : rd_s;

    rrmt_hit_unit u_hit (
        .i_rect (cmp_rect),
        .i_pt   (r_pt),
        .o_hit  (hit)
    );

    // Another entry remains to be read in the current table.
    assign issue = (r_state == S_SCAN_A) ? (r_idx < IW'(r_cnt_a)) : (r_idx < IW'(r_cnt_s));

    always_comb begin
        n_state      = r_state;
        n_cnt_a      = r_cnt_a;
        n_cnt_s      = r_cnt_s;
        n_box        = r_box;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pt         = r_pt;
        n_out_vld    = r_out_vld;
        n_out_inside = r_out_inside;
        n_out_box    = r_out_box;
        n_out_status = r_out_status;

        // Drop the result once the receiver takes it.
        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out_vld    = 1'b1;
                    n_out_inside = 1'b0;
                    n_out_box    = '0;
                    n_out_status = STAT_OK;
                    unique case (act)
                        ACT_CLEAR: begin
                            n_cnt_a = '0;
                            n_cnt_s = '0;
                            n_box   = '0;
                        end
                        ACT_ADD: begin
                            if (full_a) begin
                                n_out_status = STAT_FULL;
                            end else begin
                                n_cnt_a = r_cnt_a + 1'b1;
                                if (r_cnt_a == '0) begin
                                    n_box = in_rect;
                                end else begin
                                    if (in_rect.lo_x < r_box.lo_x) n_box.lo_x = in_rect.lo_x;
                                    if (in_rect.lo_z < r_box.lo_z) n_box.lo_z = in_rect.lo_z;
                                    if (in_rect.hi_x > r_box.hi_x) n_box.hi_x = in_rect.hi_x;
                                    if (in_rect.hi_z > r_box.hi_z) n_box.hi_z = in_rect.hi_z;
                                end
                            end
                        end
                        ACT_SUB: begin
                            if (full_s) begin
                                n_out_status = STAT_FULL;
                            end else begin
                                n_cnt_s = r_cnt_s + 1'b1;
                            end
                        end
                        ACT_SET: begin
                            n_cnt_a = CW_A'(1);
                            n_cnt_s = '0;
                            n_box   = in_rect;
                        end
                        ACT_TEST: begin
                            // Hold the result until the scan settles it.
                            n_out_vld = 1'b0;
                            n_state   = S_SCAN_A;
                            n_idx     = '0;
                            n_pend    = 1'b0;
                            n_pt      = in_pt;
                        end
                        ACT_BOUNDS: begin
                            if (r_cnt_a == '0) begin
                                n_out_status = STAT_EMPTY;
                            end else begin
                                n_out_box = r_box;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN_A: begin
                if (r_pend && hit) begin
                    // Some added rectangle holds the point: check exclusions.
                    n_state = S_SCAN_S;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                end else if (!issue && !r_pend) begin
                    n_state      = S_IDLE;
                    n_out_vld    = 1'b1;
                    n_out_inside = 1'b0;
                    n_out_box    = '0;
                    n_out_status = STAT_OK;
                end else begin
                    n_pend = issue;
                    if (issue) n_idx = r_idx + 1'b1;
                end
            end
            S_SCAN_S: begin
                if ((r_pend && hit) || (!issue && !r_pend)) begin
                    n_state      = S_IDLE;
                    n_out_vld    = 1'b1;
                    n_out_inside = !(r_pend && hit);
                    n_out_box    = '0;
                    n_out_status = STAT_OK;
                end else begin
                    n_pend = issue;
                    if (issue) n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt_a   <= '0;
            r_cnt_s   <= '0;
            r_box     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt_a   <= n_cnt_a;
            r_cnt_s   <= n_cnt_s;
            r_box     <= n_box;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
        r_idx        <= n_idx;
        r_pt         <= n_pt;
        r_out_inside <= n_out_inside;
        r_out_box    <= n_out_box;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_box.hi_z, r_out_box.hi_x,
                            r_out_box.lo_z, r_out_box.lo_x, r_out_inside};
    assign m_axis_tuser  = r_out_status;

    `RRMT_ASSERT_NOW(a_tready_out_free, i_clk, i_rst_n, s_axis_tready, (!r_out_vld || m_axis_tready))
    `RRMT_ASSERT_NOW(a_counts_bounded, i_clk, i_rst_n, 1'b1, ((r_cnt_a <= CW_A'(MAX_ADDED)) && (r_cnt_s <= CW_S'(MAX_SUBTRACTED))))
    `RRMT_ASSERT_NEXT(a_test_starts_scan, i_clk, i_rst_n, (in_acc && (act == ACT_TEST)), ((r_state == S_SCAN_A) && !r_out_vld))
    `RRMT_ASSERT_NOW(a_no_inside_with_status, i_clk, i_rst_n, (r_out_vld && (r_out_status != STAT_OK)), (!r_out_inside && (r_out_box == '0 || r_out_status == STAT_FULL || r_out_status == STAT_EMPTY)))

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for rect_region_membership_table: directed, table-full and random
// command streams, each result checked against a behavioral model of the two region tables.
// Depends on rrmt_pkg and the rect_region_membership_table RTL; reads no files.
`default_nettype none

module tb;
    import rrmt_pkg::*;

    localparam int ADD_DEPTH    = MAX_ADDED_DEF;
    localparam int CUT_DEPTH    = MAX_SUBTRACTED_DEF;
    localparam int MAX_REPORTS  = 10;
    // Leave margin after the last result.
    localparam int SETTLE_CYCLES = 60;
    localparam int DRAIN_LIMIT   = 5000;

    // Action codes the block has no meaning for; they must answer with an all-zero result.
    localparam logic [ACTION_W-1:0] ACT_RSVD_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_RSVD_B = 3'd7;

    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic    in_sel;
        t_rect   box;
        t_status status;
    } t_outcome;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata: min_x, min_z, max_x, max_z, point_x, point_z (lowest bit up)
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // tuser: action
    logic [ACTION_W-1:0]    s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata: inside_res, box_min_x, box_min_z, box_max_x, box_max_z, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // tuser: status
    logic [STATUS_W-1:0]    m_axis_tuser;

    // Model of the block: both region tables, their fill counts and the running box.
    t_rect added_tbl [ADD_DEPTH];
    int    added_n = 0;
    t_rect cut_tbl [CUT_DEPTH];
    int    cut_n = 0;
    t_rect bbox = '0;

    // Outcomes of accepted commands, oldest first.
    t_outcome pending_q [$];

    int unsigned fail_count    = 0;
    int          send_idle_pct = 11;
    int          recv_idle_pct = 55;

    rect_region_membership_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #6_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_rect make_rect(logic signed [COORD_W-1:0] lx, logic signed [COORD_W-1:0] lz,
                                        logic signed [COORD_W-1:0] hx, logic signed [COORD_W-1:0] hz);
        t_rect r;
        r.lo_x = lx;
        r.lo_z = lz;
        r.hi_x = hx;
        r.hi_z = hz;
        return r;
    endfunction

    function automatic t_point make_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] z);
        t_point p;
        p.x = x;
        p.z = z;
        return p;
    endfunction

    // Inclusive on every side; an inverted rectangle holds nothing.
    function automatic bit rect_holds(t_rect r, t_point p);
        return ($signed(p.x) >= $signed(r.lo_x)) && ($signed(p.x) <= $signed(r.hi_x)) &&
               ($signed(p.z) >= $signed(r.lo_z)) && ($signed(p.z) <= $signed(r.hi_z));
    endfunction

    // Apply one command to the model and return the result the block must give for it.
    function automatic t_outcome predict_command(logic [ACTION_W-1:0] act, t_rect r, t_point p);
        t_outcome o;
        bit       in_added;
        bit       in_cut;
        o.in_sel = 1'b0;
        o.box    = '0;
        o.status = STAT_OK;
        in_added = 1'b0;
        in_cut   = 1'b0;
        if (act == ACT_CLEAR || act == ACT_SET) begin
            added_n = 0;
            cut_n   = 0;
            bbox    = '0;
        end
        if (act == ACT_ADD || act == ACT_SET) begin
            if (added_n >= ADD_DEPTH) begin
                o.status = STAT_FULL;
            end else begin
                // First rectangle seeds the box; later ones only widen it.
                if (added_n == 0) begin
                    bbox = r;
                end else begin
                    if ($signed(r.lo_x) < $signed(bbox.lo_x)) bbox.lo_x = r.lo_x;
                    if ($signed(r.lo_z) < $signed(bbox.lo_z)) bbox.lo_z = r.lo_z;
                    if ($signed(r.hi_x) > $signed(bbox.hi_x)) bbox.hi_x = r.hi_x;
                    if ($signed(r.hi_z) > $signed(bbox.hi_z)) bbox.hi_z = r.hi_z;
                end
                added_tbl[added_n] = r;
                added_n++;
            end
        end else if (act == ACT_SUB) begin
            if (cut_n >= CUT_DEPTH) begin
                o.status = STAT_FULL;
            end else begin
                cut_tbl[cut_n] = r;
                cut_n++;
            end
        end else if (act == ACT_TEST) begin
            for (int i = 0; i < added_n; i++) if (rect_holds(added_tbl[i], p)) in_added = 1'b1;
            for (int i = 0; i < cut_n; i++) if (rect_holds(cut_tbl[i], p)) in_cut = 1'b1;
            o.in_sel = in_added && !in_cut;
        end else if (act == ACT_BOUNDS) begin
            if (added_n == 0) o.status = STAT_EMPTY;
            else o.box = bbox;
        end
        return o;
    endfunction

    // Present one command, hold it until the transaction completes, then log its outcome.
    task automatic send_cmd(logic [ACTION_W-1:0] act, t_rect r, t_point p);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {p.z, p.x, r.hi_z, r.hi_x, r.lo_z, r.lo_x};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_q.push_back(predict_command(act, r, p));
    endtask

    // Stop sending and hold off until every outstanding result has been returned.
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_q.size() != 0);
    endtask

    task automatic log_mismatch(string what, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $realtime);
    endtask

    // Receiver side: drop tready at random to stall results.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check every result transaction against the oldest outstanding outcome.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                log_mismatch("unexpected result, tuser", '0, COORD_W'(m_axis_tuser));
            end else begin
                want = pending_q.pop_front();
                if (m_axis_tdata[0] !== want.in_sel)
                    log_mismatch("inside_res", COORD_W'(want.in_sel), COORD_W'(m_axis_tdata[0]));
                if (m_axis_tdata[1 +: COORD_W] !== want.box.lo_x)
                    log_mismatch("box_min_x", want.box.lo_x, m_axis_tdata[1 +: COORD_W]);
                if (m_axis_tdata[1 + COORD_W +: COORD_W] !== want.box.lo_z)
                    log_mismatch("box_min_z", want.box.lo_z, m_axis_tdata[1 + COORD_W +: COORD_W]);
                if (m_axis_tdata[1 + 2 * COORD_W +: COORD_W] !== want.box.hi_x)
                    log_mismatch("box_max_x", want.box.hi_x,
                                 m_axis_tdata[1 + 2 * COORD_W +: COORD_W]);
                if (m_axis_tdata[1 + 3 * COORD_W +: COORD_W] !== want.box.hi_z)
                    log_mismatch("box_max_z", want.box.hi_z,
                                 m_axis_tdata[1 + 3 * COORD_W +: COORD_W]);
                if (m_axis_tdata[OUT_FIELD_W +: OUT_PAD_W] !== '0)
                    log_mismatch("tdata pad", '0, COORD_W'(m_axis_tdata[OUT_FIELD_W +: OUT_PAD_W]));
                if (m_axis_tuser !== want.status)
                    log_mismatch("status", COORD_W'(want.status), COORD_W'(m_axis_tuser));
            end
        end
    end

    // Coordinate within span of c; wraps at the ends of the range on purpose.
    function automatic logic signed [COORD_W-1:0] near(logic signed [COORD_W-1:0] c, int span);
        int off;
        off = int'($urandom_range(0, 2 * span)) - span;
        return c + off;
    endfunction

    function automatic t_rect random_rect(logic signed [COORD_W-1:0] cx,
                                          logic signed [COORD_W-1:0] cz, int span);
        t_rect r;
        r.lo_x = near(cx, span);
        r.lo_z = near(cz, span);
        r.hi_x = r.lo_x + $urandom_range(0, span);
        r.hi_z = r.lo_z + $urandom_range(0, span);
        // Now and then flip one axis so the rectangle holds nothing but still widens the box.
        if ($urandom_range(0, 9) == 0) r.hi_x = r.lo_x - 1 - $urandom_range(0, span);
        if ($urandom_range(0, 9) == 0) r.hi_z = r.lo_z - 1 - $urandom_range(0, span);
        return r;
    endfunction

    // One coordinate on or just beside an edge of [lo, hi], or its middle.
    function automatic logic signed [COORD_W-1:0] edge_coord(logic signed [COORD_W-1:0] lo,
                                                             logic signed [COORD_W-1:0] hi);
        case ($urandom_range(0, 4))
            0:       return lo - 1;
            1:       return lo;
            2:       return hi;
            3:       return hi + 1;
            default: return lo + ((hi - lo) >>> 1);
        endcase
    endfunction

    // Probe the edges of a stored rectangle most of the time, else somewhere near the center.
    function automatic t_point probe_point(logic signed [COORD_W-1:0] cx,
                                           logic signed [COORD_W-1:0] cz, int span);
        t_point p;
        t_rect  r;
        int     idx;
        int     total;
        total = added_n + cut_n;
        if (total > 0 && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, total - 1);
            r   = (idx < added_n) ? added_tbl[idx] : cut_tbl[idx - added_n];
            p.x = edge_coord(r.lo_x, r.hi_x);
            p.z = edge_coord(r.lo_z, r.hi_z);
        end else begin
            p.x = near(cx, span);
            p.z = near(cz, span);
        end
        return p;
    endfunction

    // Extremes, inclusive edges, subtraction, inverted rectangles, empty bounds and
    // unknown actions, starting from the reset state.
    task automatic test_directed();
        t_point origin;
        t_rect  none;
        origin = make_point(0, 0);
        none   = make_rect(0, 0, 0, 0);
        send_cmd(ACT_BOUNDS, none, origin);                         // empty after reset
        send_cmd(ACT_TEST, none, origin);
        send_cmd(ACT_ADD, make_rect(C_MIN, C_MIN, C_MAX, C_MAX), origin);
        send_cmd(ACT_TEST, none, make_point(C_MIN, C_MIN));
        send_cmd(ACT_TEST, none, make_point(C_MAX, C_MAX));
        send_cmd(ACT_BOUNDS, none, origin);
        send_cmd(ACT_SET, make_rect(10, 20, 30, 40), origin);
        send_cmd(ACT_TEST, none, make_point(10, 20));                // corners are inside
        send_cmd(ACT_TEST, none, make_point(30, 40));
        send_cmd(ACT_TEST, none, make_point(9, 20));
        send_cmd(ACT_TEST, none, make_point(31, 40));
        send_cmd(ACT_SUB, make_rect(15, 25, 15, 25), origin);        // single-cell hole
        send_cmd(ACT_TEST, none, make_point(15, 25));
        send_cmd(ACT_TEST, none, make_point(16, 25));
        send_cmd(ACT_BOUNDS, none, origin);                         // hole leaves box alone
        send_cmd(ACT_ADD, make_rect(50, -5, 40, -10), origin);       // inverted on both axes
        send_cmd(ACT_TEST, none, make_point(45, -7));
        send_cmd(ACT_BOUNDS, none, origin);
        send_cmd(ACT_RSVD_A, make_rect(-1, -1, -1, -1), make_point(-1, -1));
        send_cmd(ACT_RSVD_B, make_rect(-1, -1, -1, -1), make_point(-1, -1));
        send_cmd(ACT_CLEAR, none, origin);
        send_cmd(ACT_BOUNDS, none, origin);
        send_cmd(ACT_TEST, none, make_point(15, 25));
        send_cmd(ACT_SUB, make_rect(C_MIN, C_MIN, C_MAX, C_MAX), origin);
        send_cmd(ACT_BOUNDS, none, origin);                         // subtract alone stays empty
    endtask

    // Fill both tables, overflow each, and run the longest point scans.
    task automatic test_table_full();
        t_point origin;
        t_rect  none;
        origin = make_point(0, 0);
        none   = make_rect(0, 0, 0, 0);
        send_cmd(ACT_SET, make_rect(0, 0, 9, 9), origin);
        for (int i = 1; i < ADD_DEPTH; i++)
            send_cmd(ACT_ADD, make_rect(i * 10, 0, i * 10 + 9, 9), origin);
        send_cmd(ACT_ADD, make_rect(-500, -500, 600, 600), origin);  // rejected, box unchanged
        send_cmd(ACT_BOUNDS, none, origin);
        for (int i = 0; i < CUT_DEPTH; i++)
            send_cmd(ACT_SUB, make_rect(i * 10 + 5, 5, i * 10 + 5, 5), origin);
        send_cmd(ACT_SUB, make_rect(C_MIN, C_MIN, C_MAX, C_MAX), origin);
        // Hit only in the last added entry, miss every hole: full scan of both tables.
        send_cmd(ACT_TEST, none, make_point((ADD_DEPTH - 1) * 10 + 5, 2));
        send_cmd(ACT_TEST, none, make_point((CUT_DEPTH - 1) * 10 + 5, 5));
        send_cmd(ACT_TEST, none, make_point(1000, 1000));
        send_cmd(ACT_SET, make_rect(-3, -3, 3, 3), origin);
        send_cmd(ACT_BOUNDS, none, origin);
    endtask

    // Mostly well-formed build-and-probe sequences; about one draw in ten sends a single pure-noise item.
    task automatic test_random(int n_items);
        int                        sent;
        int                        span;
        int                        n_add;
        int                        n_cut;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cz;
        logic [ACTION_W-1:0]       raw_act;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                raw_act = ACTION_W'($urandom);
                send_cmd(raw_act, make_rect($urandom, $urandom, $urandom, $urandom),
                         make_point($urandom, $urandom));
                sent++;
            end else begin
                case ($urandom_range(0, 2))
                    0:       span = 3;
                    1:       span = 40;
                    default: span = 100000;
                endcase
                // Park some sequences at the ends of the range so edges wrap.
                case ($urandom_range(0, 3))
                    0:       cx = C_MIN;
                    1:       cx = C_MAX;
                    default: cx = $urandom;
                endcase
                case ($urandom_range(0, 3))
                    0:       cz = C_MIN;
                    1:       cz = C_MAX;
                    default: cz = $urandom;
                endcase
                // Open with set or clear, or keep piling onto whatever is stored.
                case ($urandom_range(0, 3))
                    0: begin
                        send_cmd(ACT_SET, random_rect(cx, cz, span), make_point(cx, cz));
                        sent++;
                    end
                    1: begin
                        send_cmd(ACT_CLEAR, random_rect(cx, cz, span), make_point(cx, cz));
                        sent++;
                    end
                    default: ;
                endcase
                n_add = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 18) : $urandom_range(0, 4);
                n_cut = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 18) : $urandom_range(0, 3);
                repeat (n_add) begin
                    send_cmd(ACT_ADD, random_rect(cx, cz, span), probe_point(cx, cz, span));
                    sent++;
                end
                repeat (n_cut) begin
                    send_cmd(ACT_SUB, random_rect(cx, cz, span), probe_point(cx, cz, span));
                    sent++;
                end
                repeat ($urandom_range(3, 10)) begin
                    if ($urandom_range(0, 4) == 0)
                        send_cmd(ACT_BOUNDS, random_rect(cx, cz, span), probe_point(cx, cz, span));
                    else
                        send_cmd(ACT_TEST, random_rect(cx, cz, span), probe_point(cx, cz, span));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int wait_cycles;
        // Hold reset asserted from time zero, then release it.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Light sender gaps, heavy receiver stalls.
        send_idle_pct = 11;
        recv_idle_pct = 55;
        test_directed();
        test_table_full();
        test_random(500);
        pause_until_drained();

        // Heavy sender gaps, light receiver stalls.
        send_idle_pct = 55;
        recv_idle_pct = 11;
        test_random(500);
        pause_until_drained();

        // Back-to-back on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(500);

        // Drain outstanding results, then watch a while for stray transactions.
        s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        do begin
            @(posedge i_clk);
            wait_cycles++;
        end while (pending_q.size() != 0 && wait_cycles < DRAIN_LIMIT);
        if (pending_q.size() != 0)
            log_mismatch("missing results, count", COORD_W'(pending_q.size()), '0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/rrmt_pkg.sv
hw/rtl/rrmt_rect_store.sv
hw/rtl/rrmt_hit_unit.sv
hw/rtl/rect_region_membership_table.sv
tb/tb.sv
